// ===== src/sprite_sort_and_batch_unit_assert.svh =====
// Assertion macros shared by the RTL
`ifndef SPRITE_SORT_AND_BATCH_UNIT_ASSERT_SVH
`define SPRITE_SORT_AND_BATCH_UNIT_ASSERT_SVH
// antecedent implies consequent in the same cycle
`define SSB_ASSERT_IMP(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
		else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define SSB_ASSERT_NXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ===== src/ssb_pkg.sv =====
// ----------------------------------------------------------------------------
// ssb_pkg
// Types, constants and compare function of the sprite sorter.
// ----------------------------------------------------------------------------
`default_nettype none
package ssb_pkg;
	localparam int SSB_MAX_SPRITES = 32;
	localparam int VERTS_PER_SPRITE = 6;
	localparam int SSB_IW = 6;  // index width, covers up to 64 cells
	localparam int SSB_LW = 7;  // run length width

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_DASC = 2'd1;
	localparam logic [1:0] MODE_DDSC = 2'd2;
	localparam logic [1:0] MODE_TASC = 2'd3;

	localparam logic [2:0] OP_HOLD  = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_SORT  = 3'd2;
	localparam logic [2:0] OP_LEN   = 3'd3;
	localparam logic [2:0] OP_SHIFT = 3'd4;

	typedef struct packed {
		logic               v;
		logic signed [15:0] depth;
		logic [31:0]        tex;
		logic [SSB_IW-1:0]  idx;
		logic               st;
		logic [SSB_LW-1:0]  len;
	} ssb_rec_t;

	// a strictly ahead of b
	function automatic logic ssb_before(input ssb_rec_t a, input ssb_rec_t b,
			input logic [1:0] mode);
		logic r;
		case (mode)
			MODE_DASC: r = a.depth < b.depth;
			MODE_DDSC: r = a.depth > b.depth;
			MODE_TASC: r = a.tex < b.tex;
			default:   r = 1'b0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== src/sprite_sort_and_batch_unit.sv =====
// Sprites load one per cycle (start with busy low). After the last sprite the
// chain runs MAX_SPRITES odd-even exchange steps, then MAX_SPRITES run length
// steps, then emits one record per cycle; busy stays high through all three.
// Results cannot be stalled. Reset clears the chain valid bits, counters and mode.
// ----------------------------------------------------------------------------
// sprite_sort_and_batch_unit
// Stable sprite sort over a chain of cells, then batch numbering and emit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sprite_sort_and_batch_unit_assert.svh"
module sprite_sort_and_batch_unit import ssb_pkg::*; #(
	parameter int MAX_SPRITES = SSB_MAX_SPRITES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sort_mode_we,
	input  wire logic [1:0]         sort_mode,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] depth_key,
	input  wire logic [31:0]        texture_id,
	input  wire logic               last_sprite,
	output logic                    result_valid,
	output logic [4:0]              source_index,
	output logic [31:0]             out_texture,
	output logic [4:0]              batch_number,
	output logic [7:0]              vertex_offset,
	output logic                    batch_start,
	output logic [7:0]              batch_vertices,
	output logic                    overflow,
	output logic                    last_record
);
	localparam int CW = $clog2(MAX_SPRITES + 1);
	localparam int PW = $clog2(MAX_SPRITES);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_LEN  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]    state_q, mode_q, cfg_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] cnt_q;
	logic          drop_q;
	logic          accept, full, fin;
	logic [2:0]    op;
	ssb_rec_t      cells [MAX_SPRITES];
	ssb_rec_t      ld_rec;
	logic [SSB_LW-1:0] blen_q, blen;
	logic [5:0]    bn_q, bn_next;
	logic [7:0]    voff_q;
	logic [9:0]    bv_full;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CW'(MAX_SPRITES));
	assign fin    = (CW'(cnt_q) + CW'(1) == count_q);

	always_comb begin
		ld_rec       = '0;
		ld_rec.depth = depth_key;
		ld_rec.tex   = texture_id;
		ld_rec.idx   = SSB_IW'(count_q);
		case (state_q)
			ST_SORT: op = OP_SORT;
			ST_LEN:  op = OP_LEN;
			ST_EMIT: op = OP_SHIFT;
			default: op = (accept && !full) ? OP_LOAD : OP_HOLD;
		endcase
	end

	for (genvar i = 0; i < MAX_SPRITES; i++) begin : g_cell
		ssb_cell #(.IDX(i), .N(MAX_SPRITES)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.ld     (count_q == CW'(i)),
			.par    (cnt_q[0]),
			.mode   (mode_q),
			.ld_rec (ld_rec),
			.lft    ((i == 0) ? ssb_rec_t'('0) : cells[(i == 0) ? 0 : i - 1]),
			.rgt    ((i == MAX_SPRITES - 1) ? ssb_rec_t'('0) :
				cells[(i == MAX_SPRITES - 1) ? i : i + 1]),
			.rec    (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= MODE_LOAD;
		end else if (sort_mode_we) begin
			cfg_q <= sort_mode;
		end
	end

	// batch bookkeeping for the head cell
	assign blen    = cells[0].st ? cells[0].len : blen_q;
	assign bn_next = (cnt_q == '0) ? 6'd0 : bn_q + 6'(cells[0].st);
	assign bv_full = 10'(blen) * 10'(VERTS_PER_SPRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_LOAD;
			count_q      <= '0;
			cnt_q        <= '0;
			drop_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= (state_q == ST_EMIT);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) drop_q <= 1'b1;
						else count_q <= count_q + CW'(1);
						if (last_sprite) begin
							mode_q  <= cfg_q;
							state_q <= ST_SORT;
							cnt_q   <= '0;
						end
					end
				end
				ST_SORT: begin
					cnt_q <= cnt_q + PW'(1);
					if (cnt_q == PW'(MAX_SPRITES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					cnt_q <= cnt_q + PW'(1);
					if (cnt_q == PW'(MAX_SPRITES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					cnt_q <= cnt_q + PW'(1);
					if (fin) begin
						cnt_q   <= '0;
						count_q <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LEN) voff_q <= 8'd0;
		if (state_q == ST_EMIT) begin
			voff_q         <= voff_q + 8'(VERTS_PER_SPRITE);
			blen_q         <= blen;
			bn_q           <= bn_next;
			source_index   <= cells[0].idx[4:0];
			out_texture    <= cells[0].tex;
			batch_number   <= bn_next[4:0];
			vertex_offset  <= voff_q;
			batch_start    <= cells[0].st;
			batch_vertices <= bv_full[7:0];
			overflow       <= drop_q;
			last_record    <= fin;
		end
	end

	`SSB_ASSERT_IMP(a_res_from_emit, clk, arst_n, result_valid, $past(state_q) == ST_EMIT)
	`SSB_ASSERT_IMP(a_count_cap, clk, arst_n, 1'b1, count_q <= CW'(MAX_SPRITES))
	`SSB_ASSERT_NXT(a_emit_done, clk, arst_n, state_q == ST_EMIT && fin, state_q == ST_IDLE && count_q == '0)
	`SSB_ASSERT_IMP(a_head_valid, clk, arst_n, state_q == ST_EMIT, cells[0].v)
endmodule
`default_nettype wire

// ===== src/ssb_cell.sv =====
// ----------------------------------------------------------------------------
// ssb_cell
// One slot of the sorting chain: load, odd-even exchange, run length, shift.
// ----------------------------------------------------------------------------
`default_nettype none
module ssb_cell import ssb_pkg::*; #(
	parameter int IDX = 0,
	parameter int N   = SSB_MAX_SPRITES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [2:0]  op,
	input  wire logic        ld,
	input  wire logic        par,
	input  wire logic [1:0]  mode,
	input  wire ssb_rec_t    ld_rec,
	input  wire ssb_rec_t    lft,
	input  wire ssb_rec_t    rgt,
	output ssb_rec_t         rec
);
	localparam logic ODD = 1'((IDX % 2) == 1);
	localparam logic HAS_R = (IDX < N - 1);
	localparam logic HAS_L = (IDX > 0);

	ssb_rec_t rec_q;
	logic pair_l, pair_r;

	assign pair_l = HAS_R && (ODD == par);
	assign pair_r = HAS_L && (ODD != par);
	assign rec = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q.v <= 1'b0;
		end else begin
			case (op)
				OP_LOAD: begin
					if (ld) begin
						rec_q.v     <= 1'b1;
						rec_q.depth <= ld_rec.depth;
						rec_q.tex   <= ld_rec.tex;
						rec_q.idx   <= ld_rec.idx;
					end
				end
				OP_SORT: begin
					// exchange only on strict order keeps the sort stable
					if (pair_l && rgt.v && ssb_before(rgt, rec_q, mode)) begin
						rec_q <= rgt;
					end else if (pair_r && rec_q.v && ssb_before(rec_q, lft, mode)) begin
						rec_q <= lft;
					end
				end
				OP_LEN: begin
					rec_q.st  <= !lft.v || (lft.tex != rec_q.tex);
					rec_q.len <= SSB_LW'(1) + ((rgt.v && rgt.tex == rec_q.tex) ?
						rgt.len : SSB_LW'(0));
				end
				OP_SHIFT: rec_q <= rgt;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks sprite sorting and batching: frames of sprites are loaded with random
// gaps, a frame model sorts and batches them, and every emitted record is
// compared field by field against the frame model's prediction.
// ----------------------------------------------------------------------------
module tb;
	import ssb_pkg::*;

	localparam int CAP = SSB_MAX_SPRITES;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [4:0]  src;
		logic [31:0] tex;
		logic [4:0]  batch;
		logic [7:0]  voff;
		logic        bstart;
		logic [7:0]  bverts;
		logic        ovf;
		logic        lastr;
	} sprite_rec_t;

	class frame_scoreboard;
		logic signed [15:0] depth_q[$];
		logic [31:0]        tex_q[$];
		logic               dropped;
		logic [1:0]         mode;
		sprite_rec_t        pending[$];
		int                 mismatches;
		int                 checked;
		int                 frames;

		function new();
			dropped = 0;
			mode = MODE_LOAD;
			mismatches = 0;
			checked = 0;
			frames = 0;
		endfunction

		function bit ahead(int a, int b);
			case (mode)
				MODE_DASC: return depth_q[a] < depth_q[b];
				MODE_DDSC: return depth_q[a] > depth_q[b];
				MODE_TASC: return tex_q[a] < tex_q[b];
				default:   return 0;
			endcase
		endfunction

		// stores one transferred sprite; on the frame's last sprite, sorts and batches
		function void note_sprite(logic signed [15:0] d, logic [31:0] t, logic fin);
			int order[CAP];
			int bnum[CAP];
			int blen[CAP];
			int n, j, b;
			sprite_rec_t r;
			if (depth_q.size() < CAP) begin
				depth_q = {depth_q, d};
				tex_q = {tex_q, t};
			end else begin
				dropped = 1;
			end
			if (!fin)
				return;
			n = depth_q.size();
			for (int i = 0; i < n; i++) begin
				j = i;
				while (j > 0 && ahead(i, order[j-1])) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = i;
			end
			b = 0;
			for (int p = 0; p < n; p++) begin
				if (p > 0 && tex_q[order[p]] != tex_q[order[p-1]])
					b++;
				bnum[p] = b;
				blen[p] = 0;
			end
			for (int p = 0; p < n; p++)
				blen[bnum[p]]++;
			for (int p = 0; p < n; p++) begin
				r.src = 5'(order[p]);
				r.tex = tex_q[order[p]];
				r.batch = 5'(bnum[p]);
				r.voff = 8'(p * VERTS_PER_SPRITE);
				r.bstart = (p == 0) || (bnum[p] != bnum[p-1]);
				r.bverts = 8'(blen[bnum[p]] * VERTS_PER_SPRITE);
				r.ovf = dropped;
				r.lastr = (p == n - 1);
				pending = {pending, r};
			end
			depth_q.delete();
			tex_q.delete();
			dropped = 0;
			frames++;
		endfunction

		function void report(string what, longint got, longint want);
			mismatches++;
			$display("ERROR record %0d: %s got %0h, expected %0h", checked, what, got, want);
		endfunction

		function void check_record(sprite_rec_t g);
			sprite_rec_t e;
			if (pending.size() == 0) begin
				report("unexpected record, source_index", g.src, 0);
				return;
			end
			e = pending.pop_front();
			if (g.src !== e.src) report("source_index", g.src, e.src);
			if (g.tex !== e.tex) report("out_texture", g.tex, e.tex);
			if (g.batch !== e.batch) report("batch_number", g.batch, e.batch);
			if (g.voff !== e.voff) report("vertex_offset", g.voff, e.voff);
			if (g.bstart !== e.bstart) report("batch_start", g.bstart, e.bstart);
			if (g.bverts !== e.bverts) report("batch_vertices", g.bverts, e.bverts);
			if (g.ovf !== e.ovf) report("overflow", g.ovf, e.ovf);
			if (g.lastr !== e.lastr) report("last_record", g.lastr, e.lastr);
			checked++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic sort_mode_we = 0;
	logic [1:0] sort_mode = MODE_LOAD;
	logic start = 0;
	logic busy;
	logic signed [15:0] depth_key = 0;
	logic [31:0] texture_id = 0;
	logic last_sprite = 0;
	logic result_valid;
	sprite_rec_t got;
	logic [3:0] modes_seen = 4'b0001;
	int cycles = 0;
	int sent = 0;
	int overflow_frames = 0;
	frame_scoreboard sb = new();

	sprite_sort_and_batch_unit dut (
		.clk(clk), .arst_n(arst_n),
		.sort_mode_we(sort_mode_we), .sort_mode(sort_mode),
		.start(start), .busy(busy),
		.depth_key(depth_key), .texture_id(texture_id), .last_sprite(last_sprite),
		.result_valid(result_valid),
		.source_index(got.src), .out_texture(got.tex), .batch_number(got.batch),
		.vertex_offset(got.voff), .batch_start(got.bstart),
		.batch_vertices(got.bverts), .overflow(got.ovf), .last_record(got.lastr)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// input transfers and result records
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_sprite(depth_key, texture_id, last_sprite);
		if (arst_n && result_valid)
			sb.check_record(got);
	end

	task automatic send_sprite(logic signed [15:0] d, logic [31:0] t, logic fin);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		repeat (gap) begin
			@(negedge clk);
			start <= 0;
		end
		@(negedge clk);
		start <= 1;
		depth_key <= d;
		texture_id <= t;
		last_sprite <= fin;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// drop start, let the frame drain, then allow for the tail of the emit
	task automatic drain();
		@(negedge clk);
		start <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_mode(logic [1:0] m);
		drain();
		@(negedge clk);
		sort_mode_we <= 1;
		sort_mode <= m;
		@(negedge clk);
		sort_mode_we <= 0;
		sort_mode <= 2'($urandom_range(0, 3));
		sb.mode = m;
		modes_seen[m] = 1'b1;
	endtask

	function automatic logic [31:0] pick_tex();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			default: return $urandom_range(1, 3);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_depth();
		case ($urandom_range(0, 4))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 4) - 2);
		endcase
	endfunction

	task automatic random_frame(int n);
		for (int i = 0; i < n; i++)
			send_sprite(pick_depth(), pick_tex(), i == n - 1);
		if (n > CAP)
			overflow_frames++;
	endtask

	initial begin
		int frame_len;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// extremes in load order, batching across equal textures
		send_sprite(-16'sd32768, 32'h0, 0);
		send_sprite(16'sd32767, 32'h0, 0);
		send_sprite(16'sd0, 32'hffff_ffff, 0);
		send_sprite(-16'sd1, 32'hffff_ffff, 1);
		// ascending depth with equal keys, must stay stable
		set_mode(MODE_DASC);
		send_sprite(16'sd5, 32'h7, 0);
		send_sprite(16'sd5, 32'h8, 0);
		send_sprite(-16'sd32768, 32'h7, 0);
		send_sprite(16'sd5, 32'h7, 1);
		// one-sprite frame
		set_mode(MODE_DDSC);
		send_sprite(16'sd32767, 32'h5555_aaaa, 1);
		send_sprite(-16'sd32768, 32'haaaa_5555, 0);
		send_sprite(16'sd32767, 32'h1, 0);
		send_sprite(16'sd32767, 32'h2, 0);
		send_sprite(16'sd0, 32'h1, 1);
		set_mode(MODE_TASC);
		send_sprite(16'sd1, 32'hffff_ffff, 0);
		send_sprite(16'sd2, 32'h0, 0);
		send_sprite(16'sd3, 32'hffff_ffff, 0);
		send_sprite(16'sd4, 32'h0, 0);
		send_sprite(16'sd5, 32'h8000_0000, 1);

		// full store and overflow, the last sprite itself dropped
		random_frame(CAP);
		set_mode(2'($urandom_range(0, 3)));
		random_frame(CAP + 4);
		while (sent < 115) begin
			if ($urandom_range(0, 2) == 0)
				set_mode(2'($urandom_range(0, 3)));
			frame_len = $urandom_range(0, 9) == 0 ? $urandom_range(CAP - 2, CAP + 3)
				: $urandom_range(1, 8);
			random_frame(frame_len);
		end
		set_mode(MODE_LOAD);
		random_frame(5);
		set_mode(MODE_TASC);
		random_frame(6);

		drain();
		repeat (100) @(posedge clk);
		$display("Ran %0d sprites in %0d frames (%0d over capacity), %0d records checked",
			sent, sb.frames, overflow_frames, sb.checked);
		$display("%0d of four sort modes used; %0d field mismatches",
			$countones(modes_seen), sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
